// ----- rtl/core/tmc_pkg.sv -----
// Shared constants, types and helpers of the touch median calibrate block.
package tmc_pkg;

  localparam int SAMPLES_PER_AXIS = 5;
  localparam int CNT_W    = $clog2(SAMPLES_PER_AXIS + 1);
  localparam int IDX_W    = (SAMPLES_PER_AXIS > 1) ? $clog2(SAMPLES_PER_AXIS) : 1;
  localparam int MED_RANK = SAMPLES_PER_AXIS / 2;

  localparam int RAW_W    = 16;
  localparam int POS_W    = 12;
  localparam int SIZE_W   = POS_W + 1;
  localparam int ORIENT_W = 3;
  localparam int PROD_W   = RAW_W + POS_W;
  localparam int STEP_W   = $clog2(POS_W + 1);

  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic FUNC_PROBE  = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  // Bit positions in the orientation register
  localparam int ORIENT_SWAP  = 0;
  localparam int ORIENT_INV_X = 1;
  localparam int ORIENT_INV_Y = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAL_X_MIN   = 3'd0,
    REG_CAL_X_MAX   = 3'd1,
    REG_CAL_Y_MIN   = 3'd2,
    REG_CAL_Y_MAX   = 3'd3,
    REG_SCREEN_W    = 3'd4,
    REG_SCREEN_H    = 3'd5,
    REG_ORIENTATION = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [RAW_W-1:0]    cal_x_min;
    logic [RAW_W-1:0]    cal_x_max;
    logic [RAW_W-1:0]    cal_y_min;
    logic [RAW_W-1:0]    cal_y_max;
    logic [SIZE_W-1:0]   screen_width;
    logic [SIZE_W-1:0]   screen_height;
    logic [ORIENT_W-1:0] orientation;
  } cfg_t;

  // Command from the front end: ok means a confirmed touch with both medians
  typedef struct packed {
    logic             ok;
    logic [RAW_W-1:0] med_x;
    logic [RAW_W-1:0] med_y;
  } cmd_t;

  // Largest screen coordinate: size clamped to 1..4096, minus one
  function automatic logic [POS_W-1:0] span_of(input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] m1;
    begin
      m1 = size - 1'b1;
      if (size == '0) begin
        span_of = '0;
      end else if (size[SIZE_W-1]) begin
        span_of = '1;
      end else begin
        span_of = m1[POS_W-1:0];
      end
    end
  endfunction

endpackage

// ----- rtl/core/touch_median_calibrate.sv -----
// Top level: configuration registers, front end, command queue and back end.
// The last sample of an axis raises full while its median is registered. A failed
// read's probe queues a command that the back end writes with valid_res low.
// A confirmed read takes its command, then per axis a setup, a multiply, 12 divide
// steps (none when the axis clamps) and a finish, then a write.
// Synchronous active-high reset: idle, queues empty, calibration at defaults.
module touch_median_calibrate
  import tmc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // input word
  input  logic                  push,
  output logic                  full,
  input  logic                  func,
  input  logic [RAW_W-1:0]      sample,
  input  logic                  pressed,
  // result word
  output logic                  empty,
  input  logic                  pop,
  output logic                  valid_res,
  output logic [RAW_W-1:0]      raw_x,
  output logic [RAW_W-1:0]      raw_y,
  output logic [POS_W-1:0]      x_pos,
  output logic [POS_W-1:0]      y_pos,
  // configuration write
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;
  logic cmd_push;
  cmd_t cmd_in;
  logic cmd_full;
  logic cmd_pop;
  cmd_t cmd_out;
  logic cmd_empty;

  // Take configuration words at any time; the user must write only while idle, the block does not enforce it
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cal_x_min     <= '0;
      cfg.cal_x_max     <= '1;
      cfg.cal_y_min     <= '0;
      cfg.cal_y_max     <= '1;
      cfg.screen_width  <= SIZE_W'(320);
      cfg.screen_height <= SIZE_W'(240);
      cfg.orientation   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CAL_X_MIN:   cfg.cal_x_min     <= cfg_data;
        REG_CAL_X_MAX:   cfg.cal_x_max     <= cfg_data;
        REG_CAL_Y_MIN:   cfg.cal_y_min     <= cfg_data;
        REG_CAL_Y_MAX:   cfg.cal_y_max     <= cfg_data;
        REG_SCREEN_W:    cfg.screen_width  <= cfg_data[SIZE_W-1:0];
        REG_SCREEN_H:    cfg.screen_height <= cfg_data[SIZE_W-1:0];
        REG_ORIENTATION: cfg.orientation   <= cfg_data[ORIENT_W-1:0];
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

  // Front end: sequence the read, hold samples, pick medians, issue commands
  tmc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .func     (func),
    .sample   (sample),
    .pressed  (pressed),
    .full     (full),
    .cmd_push (cmd_push),
    .cmd_word (cmd_in),
    .cmd_full (cmd_full)
  );

  // Hold commands so the front can keep taking words while the divider runs
  tmc_cmdq u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .wr      (cmd_push),
    .wr_word (cmd_in),
    .full    (cmd_full),
    .rd      (cmd_pop),
    .rd_word (cmd_out),
    .empty   (cmd_empty)
  );

  // Back end: calibrate both axes and hold the result word until popped
  tmc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_empty (cmd_empty),
    .cmd_word  (cmd_out),
    .cmd_pop   (cmd_pop),
    .empty     (empty),
    .pop       (pop),
    .valid_res (valid_res),
    .raw_x     (raw_x),
    .raw_y     (raw_y),
    .x_pos     (x_pos),
    .y_pos     (y_pos)
  );

endmodule

// ----- rtl/core/tmc_cmdq.sv -----
// Short command queue between the front end and the calibration back end.
module tmc_cmdq
  import tmc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  cmd_t wr_word,
  output logic full,
  input  logic rd,
  output cmd_t rd_word,
  output logic empty
);

  cmd_t                  entries [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wp;
  logic [CMDQ_PTR_W-1:0] rp;
  logic [CMDQ_CNT_W-1:0] count;
  logic                  do_wr;
  logic                  do_rd;

  assign full    = (count == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr & ~full;
  assign do_rd   = rd & ~empty;
  assign rd_word = entries[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wp <= (wp == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (do_rd) begin
        rp <= (rp == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wp] <= wr_word;
    end
  end

endmodule

// ----- rtl/core/tmc_front.sv -----
// Front end: read sequencing, sample store, median select and command issue.
module tmc_front
  import tmc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic             func,
  input  logic [RAW_W-1:0] sample,
  input  logic             pressed,
  output logic             full,
  output logic             cmd_push,
  output cmd_t             cmd_word,
  input  logic             cmd_full
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SAMP_X,
    PH_SAMP_Y,
    PH_CONFIRM
  } phase_t;

  phase_t           phase;
  logic [CNT_W-1:0] cnt;
  logic             med_pending;
  logic             med_is_y;
  logic [RAW_W-1:0] store [SAMPLES_PER_AXIS];
  logic [RAW_W-1:0] median_x;
  logic [RAW_W-1:0] median_y;
  logic [RAW_W-1:0] med_val;
  logic [CNT_W-1:0] rank;
  logic             acc;
  logic             sampling;

  assign full     = med_pending | cmd_full;
  assign acc      = push & ~full;
  assign sampling = (phase == PH_SAMP_X) || (phase == PH_SAMP_Y);

  // Every probe that does not open a read yields a result
  assign cmd_push       = acc && (func == FUNC_PROBE) && !((phase == PH_IDLE) && pressed);
  assign cmd_word.ok    = (phase == PH_CONFIRM) && pressed;
  assign cmd_word.med_x = median_x;
  assign cmd_word.med_y = median_y;

  // Rank each sample, ties broken by position; the middle rank is the median
  always_comb begin
    med_val = '0;
    rank    = '0;
    for (int i = 0; i < SAMPLES_PER_AXIS; i++) begin
      rank = '0;
      for (int j = 0; j < SAMPLES_PER_AXIS; j++) begin
        if ((j != i) && ((store[j] < store[i]) || ((store[j] == store[i]) && (j < i)))) begin
          rank = rank + 1'b1;
        end
      end
      if (rank == CNT_W'(MED_RANK)) begin
        med_val = med_val | store[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      cnt         <= '0;
      med_pending <= 1'b0;
      med_is_y    <= 1'b0;
    end else begin
      med_pending <= acc && (func == FUNC_SAMPLE) && sampling &&
                     (cnt == CNT_W'(SAMPLES_PER_AXIS - 1));
      if (acc) begin
        if (func == FUNC_PROBE) begin
          cnt <= '0;
          if ((phase == PH_IDLE) && pressed) begin
            phase <= PH_SAMP_X;
          end else begin
            phase <= PH_IDLE;
          end
        end else if (sampling) begin
          if (cnt == CNT_W'(SAMPLES_PER_AXIS - 1)) begin
            cnt         <= '0;
            med_is_y    <= (phase == PH_SAMP_Y);
            phase       <= (phase == PH_SAMP_X) ? PH_SAMP_Y : PH_CONFIRM;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && (func == FUNC_SAMPLE) && sampling) begin
      store[cnt[IDX_W-1:0]] <= sample;
    end
    if (med_pending) begin
      if (med_is_y) begin
        median_y <= med_val;
      end else begin
        median_x <= med_val;
      end
    end
  end

endmodule

// ----- rtl/core/tmc_back.sv -----
// Back end: clamp, scale through a shared serial divider, invert, result register.
module tmc_back
  import tmc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             cmd_empty,
  input  cmd_t             cmd_word,
  output logic             cmd_pop,
  output logic             empty,
  input  logic             pop,
  output logic             valid_res,
  output logic [RAW_W-1:0] raw_x,
  output logic [RAW_W-1:0] raw_y,
  output logic [POS_W-1:0] x_pos,
  output logic [POS_W-1:0] y_pos
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_WRITE
  } state_t;

  state_t            state;
  logic              axis;
  logic [STEP_W-1:0] steps;
  logic              ok;
  logic [RAW_W-1:0]  med_x;
  logic [RAW_W-1:0]  med_y;
  logic [RAW_W-1:0]  diff;
  logic [RAW_W-1:0]  den;
  logic [POS_W-1:0]  span;
  logic              fixed;
  logic [POS_W-1:0]  fixed_val;
  logic              inv;
  logic [RAW_W-1:0]  rem;
  logic [POS_W-1:0]  quo;
  logic [POS_W-1:0]  xp;
  logic [POS_W-1:0]  yp;
  logic              out_valid;

  logic [RAW_W-1:0]  raw_sel;
  logic [RAW_W-1:0]  lo_sel;
  logic [RAW_W-1:0]  hi_sel;
  logic [SIZE_W-1:0] size_sel;
  logic              inv_sel;
  logic [POS_W-1:0]  span_sel;
  logic [PROD_W-1:0] prod;
  logic [RAW_W:0]    shifted;
  logic              ge;
  logic [RAW_W:0]    sub;
  logic [POS_W-1:0]  t;

  assign cmd_pop = (state == ST_IDLE) && !cmd_empty;
  assign empty   = ~out_valid;

  // Axis 0 feeds the column, axis 1 the row; swap exchanges the medians
  always_comb begin
    raw_sel  = (axis ^ cfg.orientation[ORIENT_SWAP]) ? med_y : med_x;
    lo_sel   = axis ? cfg.cal_y_min : cfg.cal_x_min;
    hi_sel   = axis ? cfg.cal_y_max : cfg.cal_x_max;
    size_sel = axis ? cfg.screen_height : cfg.screen_width;
    inv_sel  = axis ? cfg.orientation[ORIENT_INV_Y] : cfg.orientation[ORIENT_INV_X];
    span_sel = span_of(size_sel);
  end

  assign prod    = PROD_W'(diff) * PROD_W'(span);
  assign shifted = {rem, quo[POS_W-1]};
  assign ge      = (shifted >= {1'b0, den});
  assign sub     = shifted - {1'b0, den};

  always_comb begin
    t = fixed ? fixed_val : quo;
    if (inv) begin
      t = span - t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      axis      <= 1'b0;
      steps     <= '0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!cmd_empty) begin
            ok    <= cmd_word.ok;
            med_x <= cmd_word.med_x;
            med_y <= cmd_word.med_y;
            axis  <= 1'b0;
            state <= cmd_word.ok ? ST_SETUP : ST_WRITE;
          end
        end
        ST_SETUP: begin
          span      <= span_sel;
          inv       <= inv_sel;
          diff      <= raw_sel - lo_sel;
          den       <= hi_sel - lo_sel;
          fixed     <= (raw_sel <= lo_sel) || (raw_sel >= hi_sel);
          fixed_val <= (raw_sel <= lo_sel) ? '0 : span_sel;
          state     <= ST_MUL;
        end
        ST_MUL: begin
          // Quotient stays below 2^POS_W, so the upper bits start as remainder
          rem   <= prod[PROD_W-1:POS_W];
          quo   <= prod[POS_W-1:0];
          steps <= STEP_W'(POS_W);
          state <= fixed ? ST_FIN : ST_DIV;
        end
        ST_DIV: begin
          rem   <= ge ? sub[RAW_W-1:0] : shifted[RAW_W-1:0];
          quo   <= {quo[POS_W-2:0], ge};
          steps <= steps - 1'b1;
          if (steps == STEP_W'(1)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (axis) begin
            yp    <= t;
            state <= ST_WRITE;
          end else begin
            xp    <= t;
            axis  <= 1'b1;
            state <= ST_SETUP;
          end
        end
        ST_WRITE: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            valid_res <= ok;
            raw_x     <= ok ? med_x : '0;
            raw_y     <= ok ? med_y : '0;
            x_pos     <= ok ? xp : '0;
            y_pos     <= ok ? yp : '0;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
